[src/planar_graph_six_coloring_defines.svh]
// Assertion macros for the six-colouring block.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef PLANAR_GRAPH_SIX_COLORING_DEFINES_SVH
`define PLANAR_GRAPH_SIX_COLORING_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PGSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expression must never hold
`define PGSC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

[src/pgsc_pkg.sv]
// Shared constants, types and helper functions for the six-colouring block.
// No dependencies.
package pgsc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = 5;
    localparam int CNT_W        = 6;
    localparam int ROW_W        = 32;
    localparam int COL_W        = 3;
    localparam int NUM_COLOURS  = 6;
    localparam int DEG_LIMIT    = 6;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(32);
    localparam logic [CNT_W-1:0] VCOUNT_LIMIT = CNT_W'((MAX_VERTICES < 32) ? MAX_VERTICES : 32);

    typedef struct packed {
        logic             en;
        logic [VTX_W-1:0] addr;
        logic [ROW_W-1:0] data;
    } t_adj_wr;

    typedef struct packed {
        logic             en;
        logic [VTX_W-1:0] addr;
    } t_adj_rd;

    typedef struct packed {
        logic done;
        logic failed;
    } t_eng_status;

    // zero reads as one, anything above the limit saturates
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0)
            r = CNT_W'(1);
        else if (c > VCOUNT_LIMIT)
            r = VCOUNT_LIMIT;
        return r;
    endfunction

    // n is 1..32: low n bits set
    function automatic logic [ROW_W-1:0] used_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] ones;
        ones = {ROW_W{1'b1}};
        return ones >> (CNT_W'(ROW_W) - n);
    endfunction

endpackage

[src/pgsc_if.sv]
// Handshake channels of the six-colouring block: row input, result output, config.
// Depends on pgsc_pkg.
interface pgsc_in_if import pgsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] row_index;
    logic [ROW_W-1:0] neighbour_bits;
    logic             last_row;

    modport source (output valid, output row_index, output neighbour_bits, output last_row,
                    input ready);
    modport sink   (input valid, input row_index, input neighbour_bits, input last_row,
                    output ready);
endinterface

interface pgsc_out_if import pgsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] vertex;
    logic [COL_W-1:0] colour;
    logic             failed;
    logic             last;

    modport source (output valid, output vertex, output colour, output failed, output last,
                    input ready);
    modport sink   (input valid, input vertex, input colour, input failed, input last,
                    output ready);
endinterface

interface pgsc_cfg_if import pgsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink   (input valid, input vertex_count, output ready);
endinterface

[src/pgsc_adj_mem.sv]
// Adjacency row store: one write port, one read port, registered read data.
// Depends on pgsc_pkg.
module pgsc_adj_mem import pgsc_pkg::*; (
    input  logic             i_clk,
    input  t_adj_wr          i_wr,
    input  t_adj_rd          i_rd,
    output logic [ROW_W-1:0] o_rdata
);

    logic [ROW_W-1:0] r_mem [MAX_VERTICES];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/pgsc_engine.sv]
// Elimination scan and reverse-order colouring over the adjacency store.
// Holds the removal order memory and the per-colour vertex masks. Depends on pgsc_pkg.
module pgsc_engine import pgsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_n,
    output t_adj_rd          o_adj_rd,
    input  logic [ROW_W-1:0] i_adj_data,
    output t_eng_status      o_status,
    input  logic [VTX_W-1:0] i_rd_vertex,
    output logic [COL_W-1:0] o_rd_colour
);

    typedef enum logic [2:0] {
        E_IDLE   = 3'b001,
        E_SCAN   = 3'b010,
        E_COLOUR = 3'b100
    } t_eng_state;

    t_eng_state       r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic [ROW_W-1:0] r_remaining, n_remaining;
    logic [CNT_W-1:0] r_step, n_step;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic             r_pend_valid, n_pend_valid;
    logic [VTX_W-1:0] r_pend_v, n_pend_v;
    logic [VTX_W-1:0] r_cidx, n_cidx;
    logic [CNT_W-1:0] r_col_left, n_col_left;
    logic             r_a_valid, n_a_valid;
    logic             r_b_valid, n_b_valid;
    logic [VTX_W-1:0] r_b_u, n_b_u;
    logic [ROW_W-1:0] r_coloured, n_coloured;

    logic [VTX_W-1:0] r_order_mem [MAX_VERTICES];
    logic [VTX_W-1:0] r_order_q;
    logic [ROW_W-1:0] r_cmask [NUM_COLOURS];

    logic             ord_we;
    logic             ord_re;
    logic             cmask_clr;
    logic             cmask_we;
    logic [ROW_W-1:0] cand_row;
    logic             qualify;
    logic [ROW_W-1:0] nbrs;
    logic [NUM_COLOURS-1:0] taken;
    logic [COL_W-1:0] pick;

    // adder tree: pairs, nibbles, bytes, halves
    function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] x);
        logic [1:0] p2  [ROW_W/2];
        logic [2:0] p4  [ROW_W/4];
        logic [3:0] p8  [ROW_W/8];
        logic [4:0] p16 [ROW_W/16];
        for (int g = 0; g < ROW_W / 2; g++) begin
            p2[g] = {1'b0, x[2*g]} + {1'b0, x[2*g+1]};
        end
        for (int g = 0; g < ROW_W / 4; g++) begin
            p4[g] = {1'b0, p2[2*g]} + {1'b0, p2[2*g+1]};
        end
        for (int g = 0; g < ROW_W / 8; g++) begin
            p8[g] = {1'b0, p4[2*g]} + {1'b0, p4[2*g+1]};
        end
        for (int g = 0; g < ROW_W / 16; g++) begin
            p16[g] = {1'b0, p8[2*g]} + {1'b0, p8[2*g+1]};
        end
        return {1'b0, p16[0]} + {1'b0, p16[1]};
    endfunction

    // candidate degree among remaining vertices, own bit dropped
    assign cand_row = i_adj_data & r_remaining & ~(ROW_W'(1) << r_pend_v);
    assign qualify  = r_pend_valid && r_remaining[r_pend_v]
                      && (popcount(cand_row) < CNT_W'(DEG_LIMIT));

    // colouring: neighbours already coloured were present at this vertex's removal
    assign nbrs = i_adj_data & r_coloured & ~(ROW_W'(1) << r_b_u);

    always_comb begin
        for (int c = 0; c < NUM_COLOURS; c++) begin
            taken[c] = |(nbrs & r_cmask[c]);
        end
        pick = '0;
        for (int c = NUM_COLOURS - 1; c >= 0; c--) begin
            if (!taken[c])
                pick = COL_W'(c);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_remaining  = r_remaining;
        n_step       = r_step;
        n_scan       = r_scan;
        n_pend_valid = r_pend_valid;
        n_pend_v     = r_pend_v;
        n_cidx       = r_cidx;
        n_col_left   = r_col_left;
        n_a_valid    = r_a_valid;
        n_b_valid    = r_b_valid;
        n_b_u        = r_b_u;
        n_coloured   = r_coloured;
        o_adj_rd     = '0;
        o_status     = '0;
        ord_we       = 1'b0;
        ord_re       = 1'b0;
        cmask_clr    = 1'b0;
        cmask_we     = 1'b0;

        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_n          = i_n;
                    n_remaining  = used_mask(i_n);
                    n_step       = '0;
                    n_scan       = '0;
                    n_pend_valid = 1'b0;
                    n_coloured   = '0;
                    cmask_clr    = 1'b1;
                    n_state      = E_SCAN;
                end
            end
            E_SCAN: begin
                if (qualify) begin
                    ord_we      = 1'b1;
                    n_remaining = r_remaining & ~(ROW_W'(1) << r_pend_v);
                    n_step      = r_step + CNT_W'(1);
                    if (r_step + CNT_W'(1) == r_n) begin
                        n_state      = E_COLOUR;
                        n_pend_valid = 1'b0;
                        n_cidx       = VTX_W'(r_n - CNT_W'(1));
                        n_col_left   = r_n;
                        n_a_valid    = 1'b0;
                        n_b_valid    = 1'b0;
                    end else begin
                        // restart the scan from vertex zero at once
                        o_adj_rd     = '{en: 1'b1, addr: '0};
                        n_pend_valid = 1'b1;
                        n_pend_v     = '0;
                        n_scan       = CNT_W'(1);
                    end
                end else if (r_scan < r_n) begin
                    o_adj_rd     = '{en: 1'b1, addr: r_scan[VTX_W-1:0]};
                    n_pend_valid = 1'b1;
                    n_pend_v     = r_scan[VTX_W-1:0];
                    n_scan       = r_scan + CNT_W'(1);
                end else if (r_pend_valid) begin
                    n_pend_valid = 1'b0;
                end else begin
                    o_status = '{done: 1'b1, failed: 1'b1};
                    n_state  = E_IDLE;
                end
            end
            E_COLOUR: begin
                if (r_col_left != '0) begin
                    ord_re     = 1'b1;
                    n_a_valid  = 1'b1;
                    n_cidx     = r_cidx - VTX_W'(1);
                    n_col_left = r_col_left - CNT_W'(1);
                end else begin
                    n_a_valid = 1'b0;
                end
                if (r_a_valid) begin
                    o_adj_rd  = '{en: 1'b1, addr: r_order_q};
                    n_b_valid = 1'b1;
                    n_b_u     = r_order_q;
                end else begin
                    n_b_valid = 1'b0;
                end
                if (r_b_valid) begin
                    cmask_we          = 1'b1;
                    n_coloured[r_b_u] = 1'b1;
                    if (!r_a_valid && r_col_left == '0) begin
                        o_status = '{done: 1'b1, failed: 1'b0};
                        n_state  = E_IDLE;
                    end
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= E_IDLE;
            r_pend_valid <= 1'b0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_step       <= '0;
            r_scan       <= '0;
            r_col_left   <= '0;
            r_n          <= VCOUNT_RESET;
            r_remaining  <= '1;
            r_coloured   <= '0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_a_valid    <= n_a_valid;
            r_b_valid    <= n_b_valid;
            r_step       <= n_step;
            r_scan       <= n_scan;
            r_col_left   <= n_col_left;
            r_n          <= n_n;
            r_remaining  <= n_remaining;
            r_coloured   <= n_coloured;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_v <= n_pend_v;
        r_cidx   <= n_cidx;
        r_b_u    <= n_b_u;
    end

    // removal order store
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_order_mem[r_step[VTX_W-1:0]] <= r_pend_v;
        end
        if (ord_re) begin
            r_order_q <= r_order_mem[r_cidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmask_clr) begin
            for (int c = 0; c < NUM_COLOURS; c++) begin
                r_cmask[c] <= '0;
            end
        end else if (cmask_we) begin
            r_cmask[pick][r_b_u] <= 1'b1;
        end
    end

    always_comb begin
        o_rd_colour = '0;
        for (int c = 0; c < NUM_COLOURS; c++) begin
            if (r_cmask[c][i_rd_vertex])
                o_rd_colour = COL_W'(c);
        end
    end

endmodule

[src/planar_graph_six_coloring.sv]
// Six-colouring of a graph of up to 32 vertices. Rows load at one beat per cycle, but
// not during a run or while results leave. The last row starts a run: the elimination
// scan re-reads rows from vertex 0 after each removal, one row read per cycle, then
// colouring runs; results leave at one beat per cycle while the sink is ready (n
// beats, or one on failure). Synchronous active-low reset clears control state and
// sets vertex_count to 32; the row, order and colour stores are not cleared. Depends on pgsc_pkg, pgsc_if.
`include "planar_graph_six_coloring_defines.svh"
module planar_graph_six_coloring import pgsc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    pgsc_cfg_if.sink   i_cfg,
    pgsc_in_if.sink    i_in,
    pgsc_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_RUN  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_vertex_count;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_fail, n_fail;
    logic [VTX_W-1:0] r_emit_v, n_emit_v;
    logic             r_out_valid, n_out_valid;
    logic [VTX_W-1:0] r_out_vertex, n_out_vertex;
    logic [COL_W-1:0] r_out_colour, n_out_colour;
    logic             r_out_failed, n_out_failed;
    logic             r_out_last, n_out_last;

    logic             in_accept;
    logic             start;
    logic             out_free;
    logic             emit_last;
    t_adj_wr          adj_wr;
    t_adj_rd          adj_rd;
    logic [ROW_W-1:0] adj_rdata;
    t_eng_status      eng_status;
    logic [COL_W-1:0] eng_colour;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_LOAD);
    assign in_accept   = i_in.valid && i_in.ready;
    assign start       = in_accept && i_in.last_row;

    assign adj_wr = '{en:   in_accept && ({1'b0, i_in.row_index} < CNT_W'(MAX_VERTICES)),
                      addr: i_in.row_index,
                      data: i_in.neighbour_bits};

    pgsc_adj_mem u_adj_mem (
        .i_clk   (i_clk),
        .i_wr    (adj_wr),
        .i_rd    (adj_rd),
        .o_rdata (adj_rdata)
    );

    pgsc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_n         (clamp_count(r_vertex_count)),
        .o_adj_rd    (adj_rd),
        .i_adj_data  (adj_rdata),
        .o_status    (eng_status),
        .i_rd_vertex (r_emit_v),
        .o_rd_colour (eng_colour)
    );

    assign out_free  = !r_out_valid || o_out.ready;
    assign emit_last = r_fail || ({1'b0, r_emit_v} == r_n - CNT_W'(1));

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_fail       = r_fail;
        n_emit_v     = r_emit_v;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_vertex = r_out_vertex;
        n_out_colour = r_out_colour;
        n_out_failed = r_out_failed;
        n_out_last   = r_out_last;

        case (r_state)
            S_LOAD: begin
                if (start) begin
                    n_n     = clamp_count(r_vertex_count);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (eng_status.done) begin
                    n_fail   = eng_status.failed;
                    n_emit_v = '0;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = r_fail ? '0 : r_emit_v;
                    n_out_colour = r_fail ? '0 : eng_colour;
                    n_out_failed = r_fail;
                    n_out_last   = emit_last;
                    n_emit_v     = r_emit_v + VTX_W'(1);
                    if (emit_last)
                        n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_vertex_count <= VCOUNT_RESET;
            r_n            <= VCOUNT_RESET;
            r_fail         <= 1'b0;
            r_emit_v       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_fail      <= n_fail;
            r_emit_v    <= n_emit_v;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_vertex_count <= i_cfg.vertex_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_vertex <= n_out_vertex;
        r_out_colour <= n_out_colour;
        r_out_failed <= n_out_failed;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.vertex = r_out_vertex;
    assign o_out.colour = r_out_colour;
    assign o_out.failed = r_out_failed;
    assign o_out.last   = r_out_last;

    `PGSC_ASSERT_NEVER(a_done_only_in_run, eng_status.done && (r_state != S_RUN), "engine finished outside a run")
    `PGSC_ASSERT_IMP(a_fail_beat_shape, r_out_valid && r_out_failed, r_out_last && (r_out_vertex == '0) && (r_out_colour == '0), "failure beat malformed")
    `PGSC_ASSERT_IMP(a_colour_range, r_out_valid, r_out_colour < COL_W'(NUM_COLOURS), "colour out of range")

endmodule

[dv/planar_graph_six_coloring_tb.sv]
// Self-checking testbench for planar_graph_six_coloring: loads adjacency rows, predicts
// the six-colouring of each run and compares every result beat in order.
// Depends on pgsc_pkg and the pgsc_*_if interfaces.
`timescale 1ns / 1ps

module planar_graph_six_coloring_tb;
    import pgsc_pkg::*;

    localparam int RANDOM_ITEMS  = 250;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic [COL_W-1:0] colour;
        logic             failed;
        logic             last;
    } t_colour_beat;

    function automatic logic [ROW_W-1:0] low_ones(input int n);
        return (n >= ROW_W) ? {ROW_W{1'b1}} : (ROW_W'(1) << n) - ROW_W'(1);
    endfunction

    class colouring_scoreboard;
        logic [ROW_W-1:0] adj [MAX_VERTICES];
        logic [CNT_W-1:0] vcount;
        t_colour_beat     expected_colours [$];
        int               error_count;

        function new();
            vcount = VCOUNT_RESET;
            error_count = 0;
            foreach (adj[i]) adj[i] = '0;
        endfunction

        function int active_count();
            if (vcount == 0) return 1;
            if (vcount > MAX_VERTICES) return MAX_VERTICES;
            return int'(vcount);
        endfunction

        // diagonal bit dropped
        function logic [ROW_W-1:0] own_row(input int v);
            return adj[v] & ~(ROW_W'(1) << v);
        endfunction

        function void accept_row(input logic [VTX_W-1:0] row, input logic [ROW_W-1:0] bits,
                                 input logic last_row);
            logic [ROW_W-1:0] remaining;
            logic [ROW_W-1:0] present_at [MAX_VERTICES];
            logic [ROW_W-1:0] nbrs;
            logic [COL_W-1:0] colours [MAX_VERTICES];
            logic [7:0]       taken;
            int               order [MAX_VERTICES];
            int               n, step, v, u, k, c, pick;

            adj[row] = bits;
            if (!last_row) return;

            n = active_count();
            remaining = low_ones(n);
            for (step = 0; step < n; step++) begin
                pick = -1;
                for (v = 0; v < n; v++)
                    if (pick < 0 && remaining[v] && $countones(own_row(v) & remaining) < DEG_LIMIT)
                        pick = v;
                if (pick < 0) begin
                    expected_colours.push_back('{vertex: '0, colour: '0, failed: 1'b1,
                                                 last: 1'b1});
                    return;
                end
                order[step] = pick;
                remaining[pick] = 1'b0;
                present_at[step] = remaining;
            end

            foreach (colours[i]) colours[i] = '0;
            for (step = n - 1; step >= 0; step--) begin
                u = order[step];
                nbrs = own_row(u) & present_at[step];
                taken = '0;
                for (k = 0; k < n; k++)
                    if (nbrs[k]) taken[colours[k]] = 1'b1;
                c = 0;
                while (c < NUM_COLOURS && taken[c]) c++;
                if (c >= NUM_COLOURS) c = 0;
                colours[u] = COL_W'(c);
            end

            for (v = 0; v < n; v++)
                expected_colours.push_back('{vertex: VTX_W'(v), colour: colours[v],
                                             failed: 1'b0, last: (v == n - 1)});
        endfunction

        function void check_beat(input t_colour_beat got);
            t_colour_beat want;
            if (expected_colours.size() == 0) begin
                $error("unexpected result beat: vertex %0d colour %0d failed %0b last %0b",
                       got.vertex, got.colour, got.failed, got.last);
                error_count++;
                return;
            end
            want = expected_colours.pop_front();
            if (got.vertex !== want.vertex) begin
                $error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
                error_count++;
            end
            if (got.colour !== want.colour) begin
                $error("colour: expected %0d, got %0d", want.colour, got.colour);
                error_count++;
            end
            if (got.failed !== want.failed) begin
                $error("failed: expected %0b, got %0b", want.failed, got.failed);
                error_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                error_count++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pgsc_in_if  row_ch ();
    pgsc_out_if colour_ch ();
    pgsc_cfg_if cfg_ch ();

    planar_graph_six_coloring dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (row_ch),
        .o_out   (colour_ch)
    );

    colouring_scoreboard colour_check = new();
    logic [ROW_W-1:0]    graph_rows [MAX_VERTICES];
    int                  items_sent = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return CNT_W'($urandom_range(33, 63));
        if (r < 5) return CNT_W'($urandom_range(17, 32));
        return CNT_W'($urandom_range(1, 16));
    endfunction

    task automatic send_row(input logic [VTX_W-1:0] row, input logic [ROW_W-1:0] bits,
                            input logic last_row, input bit no_idle);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_ch.valid          <= 1'b1;
        row_ch.row_index      <= row;
        row_ch.neighbour_bits <= bits;
        row_ch.last_row       <= last_row;
        do @(posedge clk); while (!row_ch.ready);
        colour_check.accept_row(row, bits, last_row);
        items_sent++;
        @(negedge clk);
    endtask

    // hold rows back until every expected beat is out, then let the block go quiet
    task automatic settle();
        row_ch.valid <= 1'b0;
        while (colour_check.expected_colours.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        settle();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.vertex_count <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        colour_check.vcount = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic build_graph(input int n);
        int mode, pct, i, j;
        mode = $urandom_range(0, 9);
        pct = (mode < 6) ? $urandom_range(3, 25) : $urandom_range(40, 100);
        for (i = 0; i < MAX_VERTICES; i++) graph_rows[i] = '0;
        if (mode == 9) begin
            // one-sided adjacency
            for (i = 0; i < MAX_VERTICES; i++) graph_rows[i] = $urandom() & $urandom();
        end else begin
            for (i = 0; i < n; i++)
                for (j = i + 1; j < n; j++)
                    if ($urandom_range(0, 99) < pct) begin
                        graph_rows[i][j] = 1'b1;
                        graph_rows[j][i] = 1'b1;
                    end
        end
        if ($urandom_range(0, 2) == 0)
            for (i = 0; i < MAX_VERTICES; i++) graph_rows[i] |= $urandom() & ~low_ones(n);
        if ($urandom_range(0, 3) == 0)
            for (i = 0; i < MAX_VERTICES; i++) graph_rows[i][i] = 1'b1;
    endtask

    always @(posedge clk) begin
        if (rst_n && colour_ch.valid && colour_ch.ready)
            colour_check.check_beat('{vertex: colour_ch.vertex, colour: colour_ch.colour,
                                      failed: colour_ch.failed, last: colour_ch.last});
    end

    // sink side: random stalls with the odd long open stretch
    initial begin
        int gap;
        colour_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 9) == 0) begin
                colour_ch.ready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(negedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    colour_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                colour_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
    end

    initial begin
        #60_000_000;
        $display("[planar_graph_six_coloring] ERROR");
        $finish;
    end

    initial begin
        int  start_items, span, n_rows, first, k, r;
        bit  no_idle;

        rst_n                 = 1'b0;
        row_ch.valid          = 1'b0;
        row_ch.row_index      = '0;
        row_ch.neighbour_bits = '0;
        row_ch.last_row       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.vertex_count   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every row written once before anything reads it: empty graph of 32
        for (r = 0; r < MAX_VERTICES; r++)
            send_row(VTX_W'(r), '0, (r == MAX_VERTICES - 1), 1'b0);

        // K7 on vertices 0..6 cannot be peeled
        for (r = 0; r < 7; r++)
            send_row(VTX_W'(r), 32'h0000_007F, (r == 6), 1'b1);

        // count of zero acts as one; bits above the count are ignored
        write_count('0);
        send_row('0, {ROW_W{1'b1}}, 1'b1, 1'b0);

        write_count(CNT_W'(6));
        send_row(VTX_W'(5), 32'h0000_003F, 1'b1, 1'b0);

        // row 5 still lacks the edge to 6, so the first run is one-sided
        write_count(CNT_W'(7));
        send_row('0, 32'h0000_007F, 1'b1, 1'b0);
        send_row(VTX_W'(5), 32'h0000_007F, 1'b1, 1'b0);

        // saturates to 32
        write_count(CNT_W'(63));
        send_row(VTX_W'(31), {ROW_W{1'b1}}, 1'b1, 1'b0);

        // run started from a row outside the active count
        write_count(CNT_W'(4));
        send_row(VTX_W'(20), $urandom(), 1'b1, 1'b0);

        write_count(CNT_W'(32));
        send_row(VTX_W'(3), 32'hFFFF_FFF0, 1'b1, 1'b0);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0)
                write_count(pick_count());
            else if ($urandom_range(0, 5) == 0)
                settle();
            span = colour_check.active_count();
            build_graph(span);
            no_idle = ($urandom_range(0, 4) == 0);
            if (span < MAX_VERTICES && $urandom_range(0, 3) == 0)
                send_row(VTX_W'($urandom_range(span, MAX_VERTICES - 1)), $urandom(), 1'b0,
                         no_idle);
            // now and then only part of the matrix is replaced
            n_rows = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span;
            first = $urandom_range(0, span - 1);
            for (k = 0; k < n_rows; k++)
                send_row(VTX_W'((first + k) % span), graph_rows[(first + k) % span],
                         (k == n_rows - 1), no_idle);
        end

        settle();
        if (colour_check.error_count == 0)
            $display("[planar_graph_six_coloring] OK");
        else
            $display("[planar_graph_six_coloring] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/pgsc_pkg.sv
src/pgsc_if.sv
src/pgsc_adj_mem.sv
src/pgsc_engine.sv
src/planar_graph_six_coloring.sv
dv/planar_graph_six_coloring_tb.sv
